@@ rtl/mhas_pkg.sv @@
// Package: shared constants and types for the multi-hart agent scheduler.
package mhas_pkg;
  localparam int Agents = 16;
  localparam int Harts = 4;
  localparam int AgentW = 4;
  localparam int HartW = 2;
  localparam int QDepth = Harts * Agents;
  localparam int QAddrW = 6;
  localparam int QLenW = 5;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_MAIL = 3'd1;
  localparam logic [2:0] OP_NOTIFY = 3'd2;
  localparam logic [2:0] OP_YIELD = 3'd3;
  localparam logic [2:0] OP_IDLE = 3'd4;

  localparam logic [2:0] ST_UNUSED = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_WAITING = 3'd4;
  localparam logic [2:0] ST_ZOMBIE = 3'd5;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_MAIL = 2'd1;
  localparam logic [1:0] SRC_QUEUE = 2'd2;
  localparam logic [1:0] SRC_RR = 2'd3;

  // agent record: status, home, running flag + hart, mail
  typedef struct packed {
    logic [2:0] status;
    logic [HartW-1:0] home;
    logic run_valid;
    logic [HartW-1:0] run_hart;
    logic mail;
  } rec_t;

  localparam int RecW = $bits(rec_t);
endpackage

@@ rtl/mhas_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module mhas_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/multi_hart_agent_scheduler_top.sv @@
// Top level: agent scheduler sequencer around the record and run-queue memories.
//  channel | dir | beat
//  s_axis  | in  | tdata: operation, hart, agent_id, new_status, home_hart, mail_pending
//  m_axis  | out | tdata: picked_valid, picked_agent, pick_source, system_done
// One event at a time; every record or queue access has a read state and a check state.
// Record write or mail: decode, record update, then the done scan over the AGENTS records.
// Notify adds the queue add scan over the home queue.
// A yield and pick at worst: queue add, mail scan, queue scan (read, check and record state per
// entry), round-robin scan, removal and shift, done scan.
// After reset a clearing pass walks the AGENTS records before the first beat is taken.
// The result waits in an output register; an output stall holds the sequencer.
module multi_hart_agent_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [4:3] hart, [8:5] agent_id, [11:9] new_status,
  // [13:12] home_hart, [14] mail_pending
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] picked_valid, [4:1] picked_agent, [6:5] pick_source, [7] system_done
  output logic [7:0]  m_axis_tdata
);
  localparam int AW = mhas_pkg::AgentW;
  localparam int HW = mhas_pkg::HartW;
  localparam int NA = mhas_pkg::Agents;
  localparam int QW = mhas_pkg::QAddrW;
  localparam int LW = mhas_pkg::QLenW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_REC, S_ADD, S_ADDCHK, S_PICK,
    S_MRD, S_MCHK, S_QRD, S_QCHK, S_QREC, S_RRD, S_RCHK,
    S_COMMIT, S_RMRD, S_RMCHK, S_SHRD, S_SHWR,
    S_DONE, S_DRD, S_DCHK, S_OUT
  } state_t;

  state_t state;
  logic [2:0] op;
  logic [HW-1:0] hart;
  logic [AW-1:0] id;
  logic [2:0] nst;
  logic [HW-1:0] nhome;
  logic nmail;

  // record memory
  logic rwe;
  logic [AW-1:0] rwaddr, rraddr;
  mhas_pkg::rec_t rwdata, rrdata;
  logic [mhas_pkg::RecW-1:0] rrbits;
  assign rrdata = mhas_pkg::rec_t'(rrbits);

  mhas_ram #(.Width(mhas_pkg::RecW), .Depth(NA)) u_rec (
    .clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwdata), .raddr(rraddr), .rdata(rrbits)
  );

  // run queue memory: hart * AGENTS + position
  logic qwe;
  logic [QW-1:0] qwaddr, qraddr;
  logic [AW-1:0] qwdata, qrdata;
  mhas_ram #(.Width(AW), .Depth(mhas_pkg::QDepth)) u_q (
    .clk(clk), .we(qwe), .waddr(qwaddr), .wdata(qwdata), .raddr(qraddr), .rdata(qrdata)
  );

  logic [LW-1:0] qlen [mhas_pkg::Harts];
  logic [mhas_pkg::Harts-1:0] cur_valid;
  logic [AW-1:0] cur [mhas_pkg::Harts];
  logic [AW-1:0] rot;

  logic [AW-1:0] cnt;    // scan counter
  logic [AW:0] pos;      // queue position
  logic [AW-1:0] tgt;    // agent being read, added or removed
  logic [HW-1:0] tq;     // queue of tgt
  logic [LW-1:0] tn;     // length of that queue
  logic add_ret;         // 1: after add, go to pick
  logic [AW-1:0] qp_id;
  logic [1:0] src;
  logic [AW-1:0] who;
  logic done_f;
  logic [7:0] obuf;

  // memory control per state
  always_comb begin
    rwe = 1'b0;
    rwaddr = tgt;
    rwdata = rrdata;
    rraddr = tgt;
    qwe = 1'b0;
    qwaddr = {tq, pos[AW-1:0]};
    qwdata = tgt;
    qraddr = {tq, pos[AW-1:0]};
    case (state)
      S_CLEAR: begin
        rwe = 1'b1;
        rwaddr = cnt;
        rwdata = '0;
        rwdata.status = mhas_pkg::ST_UNUSED;
      end
      S_DEC: rraddr = (op == mhas_pkg::OP_YIELD) ? cur[hart] : id;
      S_REC: begin
        case (op)
          mhas_pkg::OP_WRITE: begin
            rwe = 1'b1;
            rwdata.status = nst;
            rwdata.home = nhome;
          end
          mhas_pkg::OP_MAIL: begin
            rwe = 1'b1;
            rwdata.mail = nmail;
          end
          mhas_pkg::OP_NOTIFY: begin
            rwe = rrdata.status != mhas_pkg::ST_ZOMBIE;
            rwdata.status = mhas_pkg::ST_RUNNABLE;
            rwdata.run_valid = 1'b0;
          end
          mhas_pkg::OP_YIELD: begin
            rwe = rrdata.status == mhas_pkg::ST_RUNNING;
            rwdata.status = mhas_pkg::ST_RUNNABLE;
            rwdata.run_valid = 1'b0;
          end
          default: ;
        endcase
      end
      // append at the tail once the scan found no duplicate and the queue is not full
      S_ADD: qwe = (pos == {1'b0, tn}) && (tn != LW'(NA));
      S_MRD, S_MCHK, S_DRD, S_DCHK: rraddr = cnt;
      S_QRD: qraddr = {hart, pos[AW-1:0]};
      S_QCHK: begin
        qraddr = {hart, pos[AW-1:0]};
        rraddr = qrdata;
      end
      S_QREC: rraddr = qp_id;
      S_RRD, S_RCHK: rraddr = rot + cnt;
      S_COMMIT: begin
        // rrdata still holds the record of who
        rwe = 1'b1;
        rwaddr = who;
        rwdata.status = mhas_pkg::ST_RUNNING;
        rwdata.run_valid = 1'b1;
        rwdata.run_hart = hart;
      end
      S_SHWR: begin
        qwe = 1'b1;
        qwaddr = {tq, pos[AW-1:0] - AW'(1)};
        qwdata = qrdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      pos <= '0;
      for (int h = 0; h < mhas_pkg::Harts; h++) begin
        qlen[h] <= '0;
        cur[h] <= '0;
      end
      cur_valid <= '0;
      rot <= '0;
      op <= '0;
      hart <= '0;
      id <= '0;
      tgt <= '0;
      src <= mhas_pkg::SRC_NONE;
      who <= '0;
      done_f <= 1'b0;
      obuf <= '0;
      s_axis_tready <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(NA - 1)) begin
            state <= S_IDLE;
            s_axis_tready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[2:0];
            hart <= s_axis_tdata[4:3];
            id <= s_axis_tdata[8:5];
            nst <= s_axis_tdata[11:9];
            nhome <= s_axis_tdata[13:12];
            nmail <= s_axis_tdata[14];
            s_axis_tready <= 1'b0;
            src <= mhas_pkg::SRC_NONE;
            who <= '0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          tgt <= (op == mhas_pkg::OP_YIELD) ? cur[hart] : id;
          case (op)
            mhas_pkg::OP_WRITE:
              state <= (nst > mhas_pkg::ST_ZOMBIE) ? S_DONE : S_REC;
            mhas_pkg::OP_MAIL, mhas_pkg::OP_NOTIFY: state <= S_REC;
            mhas_pkg::OP_YIELD: state <= cur_valid[hart] ? S_REC : S_PICK;
            mhas_pkg::OP_IDLE: state <= S_PICK;
            default: state <= S_DONE;
          endcase
        end
        S_REC: begin
          if ((op == mhas_pkg::OP_NOTIFY && rrdata.status != mhas_pkg::ST_ZOMBIE) ||
              (op == mhas_pkg::OP_YIELD && rrdata.status == mhas_pkg::ST_RUNNING)) begin
            tq <= rrdata.home;
            tn <= qlen[rrdata.home];
            pos <= '0;
            add_ret <= op == mhas_pkg::OP_YIELD;
            state <= S_ADD;
          end else if (op == mhas_pkg::OP_YIELD) begin
            state <= S_PICK;
          end else begin
            state <= S_DONE;
          end
        end
        S_ADD: begin
          if (pos == {1'b0, tn}) begin
            if (tn != LW'(NA)) qlen[tq] <= tn + 1'b1;
            state <= add_ret ? S_PICK : S_DONE;
          end else begin
            state <= S_ADDCHK;
          end
        end
        S_ADDCHK: begin
          if (qrdata == tgt) begin
            state <= add_ret ? S_PICK : S_DONE;
          end else begin
            pos <= pos + 1'b1;
            state <= S_ADD;
          end
        end
        S_PICK: begin
          cnt <= '0;
          state <= S_MRD;
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (rrdata.status != mhas_pkg::ST_UNUSED && rrdata.status != mhas_pkg::ST_ZOMBIE &&
              rrdata.status != mhas_pkg::ST_CREATED && rrdata.home == hart && rrdata.mail) begin
            who <= cnt;
            src <= mhas_pkg::SRC_MAIL;
            state <= S_COMMIT;
          end else if (cnt == AW'(NA - 1)) begin
            pos <= '0;
            state <= S_QRD;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_MRD;
          end
        end
        S_QRD: begin
          if (pos >= {1'b0, qlen[hart]}) begin
            cnt <= '0;
            state <= S_RRD;
          end else begin
            state <= S_QCHK;
          end
        end
        S_QCHK: begin
          qp_id <= qrdata;
          state <= S_QREC;
        end
        S_QREC: begin
          if (rrdata.status == mhas_pkg::ST_RUNNABLE && !rrdata.run_valid) begin
            who <= qp_id;
            src <= mhas_pkg::SRC_QUEUE;
            state <= S_COMMIT;
          end else begin
            pos <= pos + 1'b1;
            state <= S_QRD;
          end
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: begin
          if (rrdata.status == mhas_pkg::ST_RUNNABLE && rrdata.home == hart) begin
            who <= rot + cnt;
            rot <= rot + cnt + 1'b1;
            src <= mhas_pkg::SRC_RR;
            state <= S_COMMIT;
          end else if (cnt == AW'(NA - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_RRD;
          end
        end
        S_COMMIT: begin
          cur_valid[hart] <= 1'b1;
          cur[hart] <= who;
          tq <= rrdata.home;
          tn <= qlen[rrdata.home];
          tgt <= who;
          pos <= '0;
          state <= S_RMRD;
        end
        S_RMRD: begin
          if (pos >= {1'b0, tn}) state <= S_DONE;
          else state <= S_RMCHK;
        end
        S_RMCHK: begin
          if (qrdata == tgt) begin
            qlen[tq] <= tn - 1'b1;
            pos <= pos + 1'b1;
            state <= S_SHRD;
          end else begin
            pos <= pos + 1'b1;
            state <= S_RMRD;
          end
        end
        // move each later entry down by one
        S_SHRD: begin
          if (pos >= {1'b0, tn}) state <= S_DONE;
          else state <= S_SHWR;
        end
        S_SHWR: begin
          pos <= pos + 1'b1;
          state <= S_SHRD;
        end
        S_DONE: begin
          cnt <= '0;
          done_f <= 1'b1;
          state <= S_DRD;
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          if ((cnt != '0 && rrdata.status != mhas_pkg::ST_UNUSED &&
               rrdata.status != mhas_pkg::ST_ZOMBIE) ||
              rrdata.status == mhas_pkg::ST_RUNNABLE ||
              (rrdata.status == mhas_pkg::ST_WAITING && rrdata.mail))
            done_f <= 1'b0;
          if (cnt == AW'(NA - 1)) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_DRD;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            obuf <= {done_f, src, who, src != mhas_pkg::SRC_NONE};
            m_axis_tvalid <= 1'b1;
            s_axis_tready <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = obuf;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE)
    else $error("input open while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_no_pick_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == '0)
    else $error("empty pick carries agent or source");

  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    qlen[hart] <= LW'(NA))
    else $error("run queue length overflow");
endmodule

@@ tb/sv/multi_hart_agent_scheduler_top_test.sv @@
// Self-checking testbench for the multi-hart agent scheduler: directed table, random events.
`timescale 1ns / 100ps

module multi_hart_agent_scheduler_top_test;
  localparam int LIMIT = 2000000;
  localparam int NUM_RANDOM = 1100;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  multi_hart_agent_scheduler_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  typedef struct packed {
    logic       mail;
    logic [1:0] home;
    logic [2:0] status;
    logic [3:0] agent;
    logic [1:0] hart;
    logic [2:0] op;
  } event_t;

  typedef struct packed {
    logic       done;
    logic [1:0] src;
    logic [3:0] agent;
    logic       valid;
  } pick_t;

  // scheduler mirror
  logic [2:0] m_status [mhas_pkg::Agents];
  logic [1:0] m_home [mhas_pkg::Agents];
  logic       m_run_v [mhas_pkg::Agents];
  logic       m_mail [mhas_pkg::Agents];
  logic [3:0] m_queue [mhas_pkg::Harts][mhas_pkg::Agents];
  int         m_qlen [mhas_pkg::Harts];
  logic [3:0] m_rot;
  logic       m_cur_v [mhas_pkg::Harts];
  logic [3:0] m_cur [mhas_pkg::Harts];

  pick_t pending_picks[$];
  event_t stim_q[$];
  pick_t table_pick[$];
  logic  table_fixed[$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  int picks_seen = 0;
  int sent = 0;
  int n_directed = 0;
  logic stim_done = 1'b0;

  function automatic logic mailable(logic [2:0] s);
    return s != mhas_pkg::ST_UNUSED && s != mhas_pkg::ST_ZOMBIE &&
           s != mhas_pkg::ST_CREATED;
  endfunction

  function automatic void enqueue(int id);
    int q;
    q = m_home[id];
    for (int i = 0; i < m_qlen[q]; i++) if (m_queue[q][i] == id) return;
    if (m_qlen[q] >= mhas_pkg::Agents) return;
    m_queue[q][m_qlen[q]] = 4'(id);
    m_qlen[q]++;
  endfunction

  function automatic void dequeue(int id);
    int q;
    q = m_home[id];
    for (int i = 0; i < m_qlen[q]; i++) begin
      if (m_queue[q][i] == id) begin
        for (int j = i + 1; j < m_qlen[q]; j++) m_queue[q][j-1] = m_queue[q][j];
        m_qlen[q]--;
        return;
      end
    end
  endfunction

  function automatic logic all_done();
    for (int i = 1; i < mhas_pkg::Agents; i++)
      if (m_status[i] != mhas_pkg::ST_UNUSED && m_status[i] != mhas_pkg::ST_ZOMBIE)
        return 1'b0;
    for (int i = 0; i < mhas_pkg::Agents; i++)
      if (mailable(m_status[i]) && m_status[i] != mhas_pkg::ST_RUNNING &&
          (m_status[i] == mhas_pkg::ST_RUNNABLE || m_mail[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < mhas_pkg::Agents; i++) begin
      m_status[i] = mhas_pkg::ST_UNUSED; m_home[i] = '0; m_run_v[i] = 1'b0;
      m_mail[i] = 1'b0;
    end
    for (int h = 0; h < mhas_pkg::Harts; h++) begin
      m_qlen[h] = 0; m_cur_v[h] = 1'b0; m_cur[h] = '0;
    end
    m_rot = '0;
  endfunction

  function automatic pick_t schedule(event_t e);
    pick_t r;
    int h, who, c, idx;
    logic [1:0] src;
    r = '0; src = mhas_pkg::SRC_NONE; who = 0; h = e.hart;
    case (e.op)
      mhas_pkg::OP_WRITE: begin
        if (e.status <= mhas_pkg::ST_ZOMBIE) begin
          m_status[e.agent] = e.status;
          m_home[e.agent] = e.home;
        end
      end
      mhas_pkg::OP_MAIL: m_mail[e.agent] = e.mail;
      mhas_pkg::OP_NOTIFY: begin
        if (m_status[e.agent] != mhas_pkg::ST_ZOMBIE) begin
          m_status[e.agent] = mhas_pkg::ST_RUNNABLE;
          m_run_v[e.agent] = 1'b0;
          enqueue(e.agent);
        end
      end
      mhas_pkg::OP_YIELD, mhas_pkg::OP_IDLE: begin
        if (e.op == mhas_pkg::OP_YIELD && m_cur_v[h]) begin
          c = m_cur[h];
          if (m_status[c] == mhas_pkg::ST_RUNNING) begin
            m_status[c] = mhas_pkg::ST_RUNNABLE;
            m_run_v[c] = 1'b0;
            enqueue(c);
          end
        end
        for (int i = 0; i < mhas_pkg::Agents && src == mhas_pkg::SRC_NONE; i++)
          if (mailable(m_status[i]) && m_home[i] == h && m_mail[i]) begin
            who = i; src = mhas_pkg::SRC_MAIL;
          end
        for (int i = 0; i < m_qlen[h] && src == mhas_pkg::SRC_NONE; i++) begin
          c = m_queue[h][i];
          if (m_status[c] == mhas_pkg::ST_RUNNABLE && !m_run_v[c]) begin
            who = c; src = mhas_pkg::SRC_QUEUE;
          end
        end
        for (int i = 0; i < mhas_pkg::Agents && src == mhas_pkg::SRC_NONE; i++) begin
          idx = (m_rot + i) % mhas_pkg::Agents;
          if (m_status[idx] == mhas_pkg::ST_RUNNABLE && m_home[idx] == h) begin
            m_rot = 4'(idx + 1); who = idx; src = mhas_pkg::SRC_RR;
          end
        end
        if (src != mhas_pkg::SRC_NONE) begin
          m_cur_v[h] = 1'b1; m_cur[h] = 4'(who);
          m_status[who] = mhas_pkg::ST_RUNNING;
          m_run_v[who] = 1'b1;
          dequeue(who);
        end
      end
      default: ;
    endcase
    r.valid = src != mhas_pkg::SRC_NONE;
    r.agent = src != mhas_pkg::SRC_NONE ? who[3:0] : 4'd0;
    r.src = src;
    r.done = all_done();
    return r;
  endfunction

  function automatic event_t mk(logic [2:0] op, int hart, int agent, logic [2:0] st,
                                int home, logic mail);
    event_t e;
    e.op = op; e.hart = 2'(hart); e.agent = 4'(agent); e.status = st;
    e.home = 2'(home); e.mail = mail;
    return e;
  endfunction

  function automatic pick_t res(logic v, int agent, logic [1:0] src, logic done);
    pick_t r;
    r.valid = v; r.agent = 4'(agent); r.src = src; r.done = done;
    return r;
  endfunction

  // directed row; fixed result where obvious
  task automatic add_row(event_t e, logic fixed, pick_t r);
    stim_q.push_back(e); table_fixed.push_back(fixed); table_pick.push_back(r);
  endtask

  function automatic event_t rand_event();
    int k;
    event_t e;
    e = event_t'(15'($urandom));
    k = $urandom_range(0, 99);
    e.agent = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                            4'($urandom_range(0, 5));
    if (k < 18) begin
      e.op = mhas_pkg::OP_WRITE;
      e.status = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) :
                                               3'($urandom_range(0, 5));
    end else if (k < 30) e.op = mhas_pkg::OP_MAIL;
    else if (k < 55) e.op = mhas_pkg::OP_NOTIFY;
    else if (k < 75) e.op = mhas_pkg::OP_YIELD;
    else if (k < 95) e.op = mhas_pkg::OP_IDLE;
    else e.op = 3'($urandom_range(5, 7));
    return e;
  endfunction

  function automatic int gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sender
  initial begin
    event_t e;
    int n;
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = '0;
    clear_mirror();
    add_row(mk(mhas_pkg::OP_IDLE, 0, 0, 0, 0, 0), 1, res(0, 0, mhas_pkg::SRC_NONE, 1));
    add_row(mk(mhas_pkg::OP_YIELD, 3, 0, 0, 0, 0), 1, res(0, 0, mhas_pkg::SRC_NONE, 1));
    add_row(mk(3'd7, 3, 15, 7, 3, 1), 1, res(0, 0, mhas_pkg::SRC_NONE, 1));
    add_row(mk(mhas_pkg::OP_WRITE, 0, 15, 3'd6, 3, 0), 1,
            res(0, 0, mhas_pkg::SRC_NONE, 1));
    add_row(mk(mhas_pkg::OP_WRITE, 0, 1, mhas_pkg::ST_CREATED, 1, 0), 1,
            res(0, 0, mhas_pkg::SRC_NONE, 0));
    add_row(mk(mhas_pkg::OP_NOTIFY, 0, 1, 0, 0, 0), 1, res(0, 0, mhas_pkg::SRC_NONE, 0));
    add_row(mk(mhas_pkg::OP_IDLE, 1, 0, 0, 0, 0), 1, res(1, 1, mhas_pkg::SRC_QUEUE, 0));
    add_row(mk(mhas_pkg::OP_WRITE, 0, 15, mhas_pkg::ST_RUNNABLE, 3, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_IDLE, 3, 0, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_WRITE, 0, 2, mhas_pkg::ST_WAITING, 2, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_MAIL, 0, 2, 0, 0, 1), 0, '0);
    add_row(mk(mhas_pkg::OP_IDLE, 2, 0, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_MAIL, 0, 2, 0, 0, 1), 0, '0);
    add_row(mk(mhas_pkg::OP_IDLE, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_NOTIFY, 0, 3, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_NOTIFY, 0, 4, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_YIELD, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_YIELD, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_WRITE, 0, 3, mhas_pkg::ST_ZOMBIE, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_NOTIFY, 0, 3, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_YIELD, 1, 0, 0, 0, 0), 0, '0);
    add_row(mk(mhas_pkg::OP_MAIL, 0, 15, 0, 0, 1), 0, '0);
    add_row(mk(mhas_pkg::OP_YIELD, 3, 0, 0, 0, 0), 0, '0);
    n_directed = stim_q.size();
    for (int i = 0; i < NUM_RANDOM; i++) begin
      stim_q.push_back(rand_event()); table_fixed.push_back(0); table_pick.push_back('0);
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < stim_q.size(); i++) begin
      e = stim_q[i];
      n = gap();
      if (n != 0) begin
        s_axis_tvalid <= 0;
        repeat (n) @(posedge clk);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata <= {1'b0, e};
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      if (table_fixed[i]) begin
        void'(schedule(e));
        pending_picks.push_back(table_pick[i]);
      end else pending_picks.push_back(schedule(e));
      sent++;
    end
    s_axis_tvalid <= 0;
    stim_done = 1;
  end

  // receiver
  initial begin
    pick_t got, want;
    int n;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      n = gap();
      if (n != 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got = m_axis_tdata;
      if (pending_picks.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_picks.pop_front();
        if (got.valid != want.valid || got.agent != want.agent || got.src != want.src ||
            got.done != want.done) begin
          errors++;
          if (mismatches++ < 10)
            $display("Mismatch: exp valid=%0d agent=%0d src=%0d done=%0d, got %0d %0d %0d %0d",
                     want.valid, want.agent, want.src, want.done,
                     got.valid, got.agent, got.src, got.done);
        end
        if (got.valid) picks_seen++;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d events (%0d directed), %0d picks made, %0d mismatches",
             sent, n_directed, picks_seen, mismatches);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
